### src/rhc_pkg.sv
// Shared constants, types and the arctangent table for the RGB to HSV converter.
// No dependencies.
`default_nettype none
package rhc_pkg;

   localparam int unsigned CORDIC_STEPS = 20;
   localparam int unsigned DIV_STEPS    = 17;
   localparam int unsigned VEC_W        = 42;
   localparam int unsigned ANG_W        = 26;

   localparam logic [30:0] SQRT3_Q30     = 31'd1859775393;
   localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
   localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360 * 65536);
   localparam logic [15:0] HUE_WRAP_Q7   = 16'd46080;
   localparam logic [15:0] HUE_HALF_TURN = 16'd23040;
   localparam logic [15:0] SAT_MAX       = 16'hFFFF;

   // per-pixel flags that ride along with the rotation
   typedef struct packed {
      logic       gb_equal;
      logic       r_lt_g;
      logic       dx_neg;
      logic       g_lt_b;
      logic [7:0] max_level;
   } side_type;

   // atan(2^-i) in degrees times 65536, rounded
   function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = ANG_W'(2949120);
         5'd1:    v = ANG_W'(1740967);
         5'd2:    v = ANG_W'(919879);
         5'd3:    v = ANG_W'(466945);
         5'd4:    v = ANG_W'(234379);
         5'd5:    v = ANG_W'(117304);
         5'd6:    v = ANG_W'(58666);
         5'd7:    v = ANG_W'(29335);
         5'd8:    v = ANG_W'(14668);
         5'd9:    v = ANG_W'(7334);
         5'd10:   v = ANG_W'(3667);
         5'd11:   v = ANG_W'(1833);
         5'd12:   v = ANG_W'(917);
         5'd13:   v = ANG_W'(458);
         5'd14:   v = ANG_W'(229);
         5'd15:   v = ANG_W'(115);
         5'd16:   v = ANG_W'(57);
         5'd17:   v = ANG_W'(29);
         5'd18:   v = ANG_W'(14);
         5'd19:   v = ANG_W'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### src/rgb_to_hsv_converter_top.sv
// RGB to HSV converter, fully pipelined: vectoring CORDIC hue and restoring divider.
// Depends on rhc_pkg.
`default_nettype none
// Usage:
//   Drive req_red_in/req_green_in/req_blue_in and pulse start; a word is taken
//   at every rising edge with start high. busy is tied low: one pixel can enter
//   every clock, forever.
//   The result appears on rsp_hue_deg_q7, rsp_sat_q16 and rsp_value_level for a
//   single cycle, flagged by rsp_valid.
//   Throughput is one pixel per cycle.
//   Latency is set by the 20 CORDIC rotation stages (one micro-rotation per
//   stage), plus input, max/min, setup and two hue finishing stages. The
//   17-step saturation divider runs in parallel within the rotation stages.
//   The receiver cannot stall; results are presented once and dropped after.
//   Synchronous reset clears all valid bits; words in flight are discarded.
module rgb_to_hsv_converter_top
   import rhc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   output logic             rsp_valid,
   output logic [15:0]      rsp_hue_deg_q7,
   output logic [15:0]      rsp_sat_q16,
   output logic [7:0]       rsp_value_level
);

   assign busy = 1'b0;

   // stage A: input register
   logic       a_vld_ff;
   logic [7:0] a_r_ff, a_g_ff, a_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start;
      end
      a_r_ff <= req_red_in;
      a_g_ff <= req_green_in;
      a_b_ff <= req_blue_in;
   end

   // stage B: max/min, hue vector terms, division numerator
   logic              b_vld_ff;
   side_type          b_side_ff, b_side_in;
   logic signed [9:0] b_dx_ff, b_dx_in;
   logic [7:0]        b_dy_ff, b_dy_in;
   logic [23:0]       b_num_ff, b_num_in;
   logic [7:0]        mx, mn;

   always_comb begin
      mx = a_r_ff;
      mn = a_r_ff;
      if (a_g_ff > mx) mx = a_g_ff;
      if (a_b_ff > mx) mx = a_b_ff;
      if (a_g_ff < mn) mn = a_g_ff;
      if (a_b_ff < mn) mn = a_b_ff;
      b_dx_in = $signed({1'b0, a_r_ff, 1'b0}) - $signed({2'b00, a_g_ff})
              - $signed({2'b00, a_b_ff});
      b_dy_in = (a_g_ff > a_b_ff) ? (a_g_ff - a_b_ff) : (a_b_ff - a_g_ff);
      b_num_in = {mx - mn, 9'd0, mx[7:1]};
      b_side_in.gb_equal  = (a_g_ff == a_b_ff);
      b_side_in.r_lt_g    = (a_r_ff < a_g_ff);
      b_side_in.dx_neg    = b_dx_in[9];
      b_side_in.g_lt_b    = (a_g_ff < a_b_ff);
      b_side_in.max_level = mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_side_ff <= b_side_in;
      b_dx_ff   <= b_dx_in;
      b_dy_ff   <= b_dy_in;
      b_num_ff  <= b_num_in;
   end

   // rotation / division pipeline, index 0 is the setup stage (C)
   logic                    p_vld_ff  [0:CORDIC_STEPS];
   side_type                p_side_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] p_x_ff    [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0] p_y_ff    [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0] p_acc_ff  [0:CORDIC_STEPS];
   logic [7:0]              p_rem_ff  [0:CORDIC_STEPS];
   logic [DIV_STEPS-1:0]    p_dq_ff   [0:CORDIC_STEPS];

   logic [8:0]  abs_dx;
   logic [38:0] y_prod;

   assign abs_dx = b_dx_ff[9] ? 9'(-b_dx_ff) : b_dx_ff[8:0];
   assign y_prod = 39'(b_dy_ff) * 39'(SQRT3_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff[0] <= 1'b0;
      end else begin
         p_vld_ff[0] <= b_vld_ff;
      end
      p_side_ff[0] <= b_side_ff;
      p_x_ff[0]    <= $signed({3'd0, abs_dx, 30'd0});
      p_y_ff[0]    <= $signed({3'd0, y_prod});
      p_acc_ff[0]  <= '0;
      p_rem_ff[0]  <= {1'b0, b_num_ff[23:17]};
      p_dq_ff[0]   <= b_num_ff[16:0];
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [VEC_W-1:0] xs, ys, x_in, y_in;
      logic signed [ANG_W-1:0] acc_in;
      logic [8:0]              trial;
      logic [7:0]              rem_in;
      logic [DIV_STEPS-1:0]    dq_in;

      always_comb begin
         xs = p_x_ff[i] >>> i;
         ys = p_y_ff[i][VEC_W-1] ? -((-p_y_ff[i]) >>> i) : (p_y_ff[i] >>> i);
         x_in   = p_x_ff[i];
         y_in   = p_y_ff[i];
         acc_in = p_acc_ff[i];
         if (p_y_ff[i] > 0) begin
            x_in   = p_x_ff[i] + ys;
            y_in   = p_y_ff[i] - xs;
            acc_in = p_acc_ff[i] + atan_lut(5'(i));
         end else if (p_y_ff[i] < 0) begin
            x_in   = p_x_ff[i] - ys;
            y_in   = p_y_ff[i] + xs;
            acc_in = p_acc_ff[i] - atan_lut(5'(i));
         end
         // one restoring-division quotient bit per stage, in the first DIV_STEPS stages only
         trial  = {p_rem_ff[i], p_dq_ff[i][DIV_STEPS-1]};
         rem_in = p_rem_ff[i];
         dq_in  = p_dq_ff[i];
         if (i < DIV_STEPS) begin
            if (trial >= {1'b0, p_side_ff[i].max_level}) begin
               rem_in = 8'(trial - {1'b0, p_side_ff[i].max_level});
               dq_in  = {p_dq_ff[i][DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in = trial[7:0];
               dq_in  = {p_dq_ff[i][DIV_STEPS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            p_vld_ff[i+1] <= 1'b0;
         end else begin
            p_vld_ff[i+1] <= p_vld_ff[i];
         end
         p_side_ff[i+1] <= p_side_ff[i];
         p_x_ff[i+1]    <= x_in;
         p_y_ff[i+1]    <= y_in;
         p_acc_ff[i+1]  <= acc_in;
         p_rem_ff[i+1]  <= rem_in;
         p_dq_ff[i+1]   <= dq_in;
      end
   end

   // finish 1: fold angle into its quadrant, clamp saturation
   logic                    f_vld_ff;
   side_type                f_side_ff;
   logic signed [ANG_W-1:0] f_ang_ff, f_ang_in;
   logic [15:0]             f_sat_ff, f_sat_in;
   side_type                sd;

   always_comb begin
      sd = p_side_ff[CORDIC_STEPS];
      f_ang_in = p_acc_ff[CORDIC_STEPS];
      if (f_ang_in < 0) f_ang_in = '0;
      if (sd.dx_neg) f_ang_in = DEG180 - f_ang_in;
      if (sd.g_lt_b) f_ang_in = DEG360 - f_ang_in;
      if (f_ang_in < 0) f_ang_in = '0;
      if (sd.max_level == 8'd0) begin
         f_sat_in = '0;
      end else if (p_dq_ff[CORDIC_STEPS][16]) begin
         f_sat_in = SAT_MAX;
      end else begin
         f_sat_in = p_dq_ff[CORDIC_STEPS][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= p_vld_ff[CORDIC_STEPS];
      end
      f_side_ff <= sd;
      f_ang_ff  <= f_ang_in;
      f_sat_ff  <= f_sat_in;
   end

   // finish 2: round to Q9.7, wrap, gray handling
   logic [ANG_W-1:0] rounded;
   logic [15:0]      hue_in;

   always_comb begin
      rounded = $unsigned(f_ang_ff) + ANG_W'(256);
      hue_in  = rounded[24:9];
      if (hue_in >= HUE_WRAP_Q7) hue_in = hue_in - HUE_WRAP_Q7;
      if (f_side_ff.gb_equal) hue_in = f_side_ff.r_lt_g ? HUE_HALF_TURN : 16'd0;
   end

   logic        o_vld_ff;
   logic [15:0] o_hue_ff, o_sat_ff;
   logic [7:0]  o_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= f_vld_ff;
      end
      o_hue_ff <= hue_in;
      o_sat_ff <= f_sat_ff;
      o_val_ff <= f_side_ff.max_level;
   end

   assign rsp_valid       = o_vld_ff;
   assign rsp_hue_deg_q7  = o_hue_ff;
   assign rsp_sat_q16     = o_sat_ff;
   assign rsp_value_level = o_val_ff;

endmodule
`default_nettype wire
